@@ rtl/core/drml_pkg.sv @@
package drml_pkg;

  localparam int MaxRects = 512;
  localparam int IdxW = $clog2(MaxRects);
  localparam int CntW = IdxW + 1;

  localparam logic [1:0] ModeAdd   = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;
  localparam logic [1:0] ModeNone  = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic [15:0]        in_w;
    logic [15:0]        in_h;
    logic [8:0]         entry_index;
  } in_word_t;

  typedef struct packed {
    logic [9:0]         rect_count;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [16:0]        out_w;
    logic [16:0]        out_h;
  } out_word_t;

  // stored slot: x, y, w, h
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [16:0]        w;
    logic [16:0]        h;
  } rect_t;

endpackage

@@ rtl/core/dirty_rect_merge_list_core.sv @@
// Dirty rectangle coalescing list.
// in channel (in_valid/in_ready/in_data) takes one word per command: add a
// rectangle, read a slot, clear the count, or do nothing (ModeNone). out channel (out_valid/
// out_ready/out_data) returns one word per command with the count after it
// and, for a read, the slot contents.
// Slots live in one synchronous RAM with a registered read. An add scans
// slots from 0, reading each slot in S_SRD and comparing it in S_SCMP; every
// merge passes through S_LAST (last slot is fetched during the compare, then
// written back) and restarts the scan. A full-list collapse walks all slots
// once more. A read waits in S_RDWT before S_DONE; a clear goes straight to
// S_DONE.
// After reset a clearing pass writes zero to every slot, one per cycle;
// in_ready stays low during it.
// A held result does not block the core from finishing: the next word is
// accepted only after out is taken, so out stalls simply hold the core idle.
module dirty_rect_merge_list_core
  import drml_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;  // issue read of slot idx
  localparam logic [3:0] S_SCMP  = 4'd3;  // compare slot idx
  localparam logic [3:0] S_LAST  = 4'd4;  // data of last slot arrives
  localparam logic [3:0] S_RDWT  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;  // full collapse walk
  localparam logic [3:0] S_FCMP  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]      state;
  rect_t           mem [MaxRects];
  rect_t           rdata;
  logic [IdxW-1:0] raddr;
  logic            we;
  logic [IdxW-1:0] waddr;
  rect_t           wdata;

  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic [IdxW-1:0] hit;
  rect_t           cur;
  logic [1:0]      mode;
  logic [8:0]      ridx;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // edges in 18-bit signed
  logic signed [17:0] cl, ct, cr, cb, sl, st, sr, sb;
  logic               meet;
  rect_t              joined;
  always_comb begin
    cl = 18'(cur.x);
    ct = 18'(cur.y);
    cr = cl + $signed({1'b0, cur.w});
    cb = ct + $signed({1'b0, cur.h});
    sl = 18'(rdata.x);
    st = 18'(rdata.y);
    sr = sl + $signed({1'b0, rdata.w});
    sb = st + $signed({1'b0, rdata.h});
    meet = (cl <= sr) && (sl <= cr) && (ct <= sb) && (st <= cb);
    joined.x = (cl < sl) ? cur.x : rdata.x;
    joined.y = (ct < st) ? cur.y : rdata.y;
    joined.w = 17'(((cr > sr) ? cr : sr) - ((cl < sl) ? cl : sl));
    joined.h = 17'(((cb > sb) ? cb : sb) - ((ct < st) ? ct : st));
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    raddr = idx[IdxW-1:0];
    if (state == S_IDLE) raddr = in_data.entry_index[IdxW-1:0];
    if (state == S_RDWT) raddr = ridx[IdxW-1:0];
    if (state == S_SCMP) raddr = IdxW'(count - 1'b1);
    we = 1'b0;
    waddr = idx[IdxW-1:0];
    wdata = '0;
    unique case (state)
      S_INIT: we = 1'b1;
      S_LAST: begin
        we = 1'b1;
        waddr = hit;
        wdata = rdata;
      end
      S_SRD: if (idx >= count && count < CntW'(MaxRects)) begin
        we = 1'b1;
        waddr = count[IdxW-1:0];
        wdata = cur;
      end
      S_DONE: if (mode == ModeAdd && count == '0) begin
        we = 1'b1;
        waddr = '0;
        wdata = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      count <= '0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          idx <= idx + 1'b1;
          if (idx == CntW'(MaxRects - 1)) begin
            state <= S_IDLE;
            idx <= '0;
          end
        end
        S_IDLE: if (in_valid && in_ready) begin
          mode <= in_data.mode;
          ridx <= in_data.entry_index;
          cur <= {in_data.in_x, in_data.in_y, 1'b0, in_data.in_w, 1'b0, in_data.in_h};
          idx <= '0;
          state <= S_DONE;
          if (in_data.mode == ModeAdd && in_data.in_w != '0 && in_data.in_h != '0)
            state <= S_SRD;
          else if (in_data.mode == ModeAdd)
            mode <= ModeNone;  // ignored add: report count only
          else if (in_data.mode == ModeRead)
            state <= S_RDWT;
          else if (in_data.mode == ModeClear)
            count <= '0;
        end
        S_RDWT: state <= S_DONE;
        S_SRD: begin
          if (idx < count) state <= S_SCMP;
          else if (count < CntW'(MaxRects)) begin
            count <= count + 1'b1;
            mode <= ModeNone;
            state <= S_DONE;
          end else begin
            idx <= '0;
            state <= S_FRD;
          end
        end
        S_SCMP: begin
          if (meet) begin
            cur <= joined;
            hit <= idx[IdxW-1:0];
            count <= count - 1'b1;
            state <= S_LAST;
          end else begin
            idx <= idx + 1'b1;
            state <= S_SRD;
          end
        end
        S_LAST: begin
          idx <= '0;
          state <= S_SRD;
        end
        S_FRD: state <= S_FCMP;
        S_FCMP: begin
          cur <= joined;
          idx <= idx + 1'b1;
          if (idx == count - 1'b1) begin
            count <= '0;  // marks collapse; slot 0 written in S_DONE
            state <= S_DONE;
          end else state <= S_FRD;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_data.rect_count <= 10'(count);
          out_data.out_x <= '0;
          out_data.out_y <= '0;
          out_data.out_w <= '0;
          out_data.out_h <= '0;
          if (mode == ModeAdd) begin
            count <= CntW'(1);
            out_data.rect_count <= 10'd1;
          end
          if (mode == ModeRead && {1'b0, ridx} < CntW'(MaxRects)) begin
            out_data.out_x <= rdata.x;
            out_data.out_y <= rdata.y;
            out_data.out_w <= rdata.w;
            out_data.out_h <= rdata.h;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/drml_checker.sv @@
module drml_checker
  import drml_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.rect_count <= 10'(MaxRects))
    else $error("count beyond depth");

  a_no_take_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(in_valid && in_ready))
    else $error("input taken while word pending");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("in word changed while waiting");

endmodule

bind dirty_rect_merge_list_core drml_checker u_drml_checker (.*);

@@ verif/dirty_rect_merge_list_core_tb.sv @@
module dirty_rect_merge_list_core_tb;
  import drml_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  dirty_rect_merge_list_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  // shadow copy of the rectangle list
  logic signed [15:0] shadow_x[MaxRects];
  logic signed [15:0] shadow_y[MaxRects];
  logic [16:0]        shadow_w[MaxRects];
  logic [16:0]        shadow_h[MaxRects];
  int unsigned        shadow_count;

  out_word_t pending_words[$];
  int        err_count = 0;
  bit        no_idle = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic bit rects_touch(longint ax, longint ay, longint aw, longint ah,
                                     longint bx, longint by, longint bw, longint bh);
    return ax <= bx + bw && bx <= ax + aw && ay <= by + bh && by <= ay + ah;
  endfunction

  // fold slot i into the running union (ux, uy, uw, uh)
  task automatic union_with_slot(input int i, inout longint ux, inout longint uy,
                                 inout longint uw, inout longint uh);
    longint sx, sy, sw, sh, rgt, bot;
    sx = shadow_x[i];
    sy = shadow_y[i];
    sw = shadow_w[i];
    sh = shadow_h[i];
    rgt = ux + uw;
    bot = uy + uh;
    if (sx + sw > rgt) rgt = sx + sw;
    if (sy + sh > bot) bot = sy + sh;
    if (sx < ux) ux = sx;
    if (sy < uy) uy = sy;
    uw = rgt - ux;
    uh = bot - uy;
  endtask

  task automatic put_slot(input int i, input longint x, input longint y,
                          input longint w, input longint h);
    shadow_x[i] = x[15:0];
    shadow_y[i] = y[15:0];
    shadow_w[i] = w[16:0];
    shadow_h[i] = h[16:0];
  endtask

  task automatic merge_rect(input in_word_t w);
    longint ux, uy, uw, uh;
    int i;
    ux = w.in_x;
    uy = w.in_y;
    uw = w.in_w;
    uh = w.in_h;
    i = 0;
    while (i < shadow_count) begin
      if (!rects_touch(ux, uy, uw, uh, shadow_x[i], shadow_y[i], shadow_w[i], shadow_h[i]))
      begin
        i++;
      end else begin
        union_with_slot(i, ux, uy, uw, uh);
        shadow_count--;
        shadow_x[i] = shadow_x[shadow_count];
        shadow_y[i] = shadow_y[shadow_count];
        shadow_w[i] = shadow_w[shadow_count];
        shadow_h[i] = shadow_h[shadow_count];
        i = 0;
      end
    end
    if (shadow_count < MaxRects) begin
      put_slot(shadow_count, ux, uy, uw, uh);
      shadow_count++;
    end else begin
      for (i = 0; i < shadow_count; i++) union_with_slot(i, ux, uy, uw, uh);
      put_slot(0, ux, uy, uw, uh);
      shadow_count = 1;
    end
  endtask

  task automatic predict_word(input in_word_t w);
    out_word_t r;
    r = '0;
    case (w.mode)
      ModeAdd: begin
        if (w.in_w != 0 && w.in_h != 0) merge_rect(w);
      end
      ModeRead: begin
        r.out_x = shadow_x[w.entry_index];
        r.out_y = shadow_y[w.entry_index];
        r.out_w = shadow_w[w.entry_index];
        r.out_h = shadow_h[w.entry_index];
      end
      ModeClear: shadow_count = 0;
      default: ;
    endcase
    r.rect_count = shadow_count[9:0];
    pending_words.push_back(r);
  endtask

  // caller is at a rising edge
  task automatic send_word(input in_word_t w);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    predict_word(w);
  endtask

  function automatic in_word_t make_word(input logic [1:0] mode, input int x, input int y,
                                         input int w, input int h, input int idx);
    in_word_t r;
    r.mode = mode;
    r.in_x = x[15:0];
    r.in_y = y[15:0];
    r.in_w = w[15:0];
    r.in_h = h[15:0];
    r.entry_index = idx[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_ready <= (no_idle || rst) ? 1'b1 : ($urandom_range(99) >= 15);
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        out_word_t e;
        e = pending_words.pop_front();
        if (out_data.rect_count !== e.rect_count)
          report_mismatch($sformatf("rect_count %0d exp %0d", out_data.rect_count,
                                    e.rect_count));
        if (out_data.out_x !== e.out_x)
          report_mismatch($sformatf("out_x %0d exp %0d", out_data.out_x, e.out_x));
        if (out_data.out_y !== e.out_y)
          report_mismatch($sformatf("out_y %0d exp %0d", out_data.out_y, e.out_y));
        if (out_data.out_w !== e.out_w)
          report_mismatch($sformatf("out_w %0d exp %0d", out_data.out_w, e.out_w));
        if (out_data.out_h !== e.out_h)
          report_mismatch($sformatf("out_h %0d exp %0d", out_data.out_h, e.out_h));
      end
    end
  end

  task automatic test_directed;
    send_word(make_word(ModeRead, 0, 0, 0, 0, 511));
    send_word(make_word(ModeAdd, 5, 5, 0, 10, 0));        // empty width
    send_word(make_word(ModeAdd, 5, 5, 10, 0, 0));        // empty height
    send_word(make_word(ModeAdd, 0, 0, 10, 10, 0));
    send_word(make_word(ModeAdd, 10, 0, 5, 5, 0));        // shared edge
    send_word(make_word(ModeAdd, 15, 10, 3, 3, 0));       // corner touch
    send_word(make_word(ModeAdd, 100, 100, 1, 1, 0));     // separate
    send_word(make_word(ModeRead, 0, 0, 0, 0, 0));
    send_word(make_word(ModeRead, 0, 0, 0, 0, 1));
    send_word(make_word(ModeNone, -1, -1, 65535, 65535, 511));   // unused mode
    send_word(make_word(ModeAdd, -32768, -32768, 65535, 65535, 0));
    send_word(make_word(ModeAdd, 32767, 32767, 65535, 65535, 0));
    send_word(make_word(ModeRead, 0, 0, 0, 0, 0));
    send_word(make_word(ModeClear, 0, 0, 0, 0, 0));
    send_word(make_word(ModeRead, 0, 0, 0, 0, 0));        // stale slot
    send_word(make_word(ModeRead, 0, 0, 0, 0, 1));
    send_word(make_word(ModeAdd, 32767, -32768, 1, 65535, 0));
    send_word(make_word(ModeAdd, -32768, 32767, 65535, 1, 0));
    send_word(make_word(ModeRead, 0, 0, 0, 0, 1));
    send_word(make_word(ModeClear, -1, -1, 65535, 65535, 511));
  endtask

  // disjoint grid fills every slot, then one more add collapses the list
  task automatic test_full_collapse;
    for (int i = 0; i < MaxRects; i++)
      send_word(make_word(ModeAdd, (i % 32) * 100, (i / 32) * 100, 10, 10, 0));
    send_word(make_word(ModeRead, 0, 0, 0, 0, 511));
    send_word(make_word(ModeAdd, -5000, -5000, 3, 3, 0));
    send_word(make_word(ModeRead, 0, 0, 0, 0, 0));
    send_word(make_word(ModeRead, 0, 0, 0, 0, 300));
    send_word(make_word(ModeClear, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random;
    in_word_t w;
    int pick;
    for (int n = 0; n < 43; n++) begin
      no_idle = (n >= 10 && n < 30);
      pick = $urandom_range(99);
      w = '0;
      w.in_x = 16'($urandom);
      w.in_y = 16'($urandom);
      w.in_w = 16'($urandom);
      w.in_h = 16'($urandom);
      w.entry_index = 9'($urandom);
      if (shadow_count > 24 || pick < 4) begin
        w.mode = ModeClear;
      end else if (pick < 8) begin
        w.mode = ModeNone;
      end else if (pick < 28) begin
        w.mode = ModeRead;
        if (pick < 18 && shadow_count > 0)
          w.entry_index = 9'($urandom_range(shadow_count - 1));
      end else begin
        w.mode = ModeAdd;
        if (pick < 88) begin
          w.in_x = 16'($urandom_range(400) - 200);
          w.in_y = 16'($urandom_range(400) - 200);
          w.in_w = 16'($urandom_range(60, 1));
          w.in_h = 16'($urandom_range(60, 1));
        end else if (pick < 94) begin
          w.in_w = 16'($urandom);
          w.in_h = 16'($urandom);
        end else if (pick < 97) begin
          w.in_w = 0;
        end else begin
          w.in_h = 0;
        end
      end
      send_word(w);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MaxRects; i++) begin
      shadow_x[i] = '0;
      shadow_y[i] = '0;
      shadow_w[i] = '0;
      shadow_h[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed;
    test_full_collapse;
    test_random;
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("dirty_rect_merge_list_core_tb passed");
    end else begin
      $display("dirty_rect_merge_list_core_tb failed");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("dirty_rect_merge_list_core_tb failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/drml_pkg.sv
rtl/core/dirty_rect_merge_list_core.sv
rtl/core/drml_checker.sv
verif/dirty_rect_merge_list_core_tb.sv
